// ===== rtl/gil_pkg.sv =====
package gil_pkg;

	// command codes on the input stream
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// configuration register indexes
	localparam logic [1:0] REG_CHI_COUNT  = 2'd0;
	localparam logic [1:0] REG_ZETA_COUNT = 2'd1;
	localparam logic [1:0] REG_MIX_COUNT  = 2'd2;

	localparam int CountW = 7;
	localparam int SlotW  = 6;
	localparam int ValW   = 32;
	localparam int AxisW  = 2;
	localparam int MaxAxes = 3;

	// input word layout
	localparam int InW  = 1 + AxisW + SlotW + 4 * ValW;   // 137
	localparam int InTw = 144;
	// output word layout
	localparam int OutW  = 3 * SlotW + 3 * ValW + 3;      // 117
	localparam int OutTw = 120;

endpackage

// ===== rtl/grid_interval_locator.sv =====
// Sequence: per axis, ST_AXIS, then ST_MID_RD, ST_MID_WAIT and ST_MID_CMP per bisection step
// (up to 6 at count 64), read/setup in ST_LO_RD, ST_HI_RD, ST_HI_WAIT and ST_DIV_SET, the
// divide in ST_DIV and ST_FIN; a zero-width interval skips the divide; ST_OUT loads the result.
// One word at a time: a load is done in its accept cycle; a query holds the input until its
// result is loaded, which waits while a previous result is still held.
// Reset: arst_n clears control state and sets all counts to 2; the RAM is not cleared.
module grid_interval_locator #(
	parameter int GRID_DEPTH = 64,
	parameter int NUM_AXES   = 3
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// cmd, axis, slot, grid_value, query_chi, query_zeta, query_mix
	input  logic [gil_pkg::InTw-1:0]    s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// upper_chi, upper_zeta, upper_mix, frac_chi, frac_zeta, frac_mix,
	// zero_width_mask
	output logic [gil_pkg::OutTw-1:0]   m_tdata,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [gil_pkg::CountW-1:0]  cfg_wdata
);

	localparam int IdxW   = $clog2(GRID_DEPTH);
	localparam int IdxW1  = IdxW + 1;
	localparam int Depth  = NUM_AXES * GRID_DEPTH;
	localparam int AddrW  = $clog2(Depth);
	localparam int NumW   = 50;   // magnitude of (x-g)*65536 fits in 49 bits
	localparam int DenW   = 33;
	localparam int CntW   = $clog2(NumW + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_AXIS, ST_MID_RD, ST_MID_WAIT, ST_MID_CMP,
		ST_LO_RD, ST_HI_RD, ST_HI_WAIT, ST_DIV_SET, ST_DIV, ST_FIN, ST_OUT
	} state_t;

	state_t state_q;

	logic [gil_pkg::ValW-1:0] qx_q [gil_pkg::MaxAxes];
	logic [gil_pkg::CountW-1:0] cnt_q [gil_pkg::MaxAxes];
	logic [1:0]   ax_q;
	logic [IdxW1-1:0] lo_q, hi_q, mid;
	logic signed [DenW-1:0] glo_q, ghi_q;
	logic [NumW-1:0] quo_q;     // numerator magnitude, shifted into quotient
	logic [DenW-1:0] rem_q, dmag_q;
	logic neg_q;
	logic [CntW-1:0] dcnt_q;
	logic [gil_pkg::SlotW-1:0] up_q [gil_pkg::MaxAxes];
	logic [gil_pkg::ValW-1:0] fr_q [gil_pkg::MaxAxes];
	logic [2:0] zmask_q;
	logic [gil_pkg::OutW-1:0] out_q;

	// RAM interface
	logic             ram_we;
	logic [AddrW-1:0] ram_waddr, ram_raddr;
	logic [IdxW1-1:0] rd_idx;
	logic [gil_pkg::ValW-1:0] ram_rdata;

	// input fields
	logic in_cmd;
	logic [gil_pkg::AxisW-1:0] in_axis;
	logic [gil_pkg::SlotW-1:0] in_slot;
	logic [gil_pkg::ValW-1:0] in_val;
	assign in_cmd  = s_tdata[0];
	assign in_axis = s_tdata[2:1];
	assign in_slot = s_tdata[8:3];
	assign in_val  = s_tdata[40:9];

	assign s_tready = (state_q == ST_IDLE);
	wire accept = s_tvalid && s_tready;

	// loads write directly at accept
	always_comb begin
		ram_we    = accept && (in_cmd == gil_pkg::CMD_LOAD) && (in_axis < NUM_AXES)
			&& ({26'd0, in_slot} < 32'(GRID_DEPTH));
		ram_waddr = AddrW'(32'(in_axis) * GRID_DEPTH + 32'(in_slot));
		ram_raddr = AddrW'(32'(ax_q) * GRID_DEPTH + 32'(rd_idx));
	end

	gil_ram #(.Width(gil_pkg::ValW), .Depth(Depth)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(in_val),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	assign mid = IdxW1'((32'(hi_q) + 32'(lo_q)) >> 1);

	always_comb begin
		case (state_q)
			ST_LO_RD: rd_idx = hi_q - IdxW1'(1);
			ST_HI_RD: rd_idx = hi_q;
			default:  rd_idx = mid;
		endcase
	end

	// clamped count for the current axis
	logic [IdxW1-1:0] used;
	always_comb begin
		if (cnt_q[ax_q] < 7'd2) begin
			used = IdxW1'(2);
		end else if (32'(cnt_q[ax_q]) > GRID_DEPTH) begin
			used = IdxW1'(GRID_DEPTH);
		end else begin
			used = IdxW1'(cnt_q[ax_q]);
		end
	end

	logic signed [DenW-1:0] xs, rd_s, den, numd;
	assign xs   = DenW'($signed(qx_q[ax_q]));
	assign rd_s = DenW'($signed(ram_rdata));
	assign den  = ghi_q - glo_q;
	assign numd = xs - glo_q;

	// restoring division step
	logic [DenW:0] trial;
	assign trial = {rem_q, quo_q[NumW-1]} - {1'b0, dmag_q};

	// saturating signed fraction from magnitude
	logic [gil_pkg::ValW-1:0] fsat;
	always_comb begin
		if (neg_q) begin
			fsat = (quo_q > NumW'(33'h80000000)) ? 32'h80000000 : 32'(-quo_q);
		end else begin
			fsat = (quo_q > NumW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : quo_q[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < gil_pkg::MaxAxes; i++) begin
				cnt_q[i] <= gil_pkg::CountW'(2);
			end
			m_tvalid <= 1'b0;
			ax_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					gil_pkg::REG_CHI_COUNT:  cnt_q[0] <= cfg_wdata;
					gil_pkg::REG_ZETA_COUNT: cnt_q[1] <= cfg_wdata;
					gil_pkg::REG_MIX_COUNT:  cnt_q[2] <= cfg_wdata;
					default: ;
				endcase
			end
			// result taken; ST_OUT reloads it in the same cycle instead
			if (m_tvalid && m_tready && state_q != ST_OUT) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && in_cmd == gil_pkg::CMD_QUERY) begin
						qx_q[0] <= s_tdata[72:41];
						qx_q[1] <= s_tdata[104:73];
						qx_q[2] <= s_tdata[136:105];
						ax_q <= '0;
						zmask_q <= '0;
						state_q <= ST_AXIS;
					end
				end
				ST_AXIS: begin
					if (32'(ax_q) >= NUM_AXES) begin
						up_q[ax_q] <= 6'd1;
						fr_q[ax_q] <= '0;
						state_q <= ST_FIN;
					end else begin
						lo_q <= '0;
						hi_q <= used - IdxW1'(1);
						state_q <= (used == IdxW1'(2)) ? ST_LO_RD : ST_MID_RD;
					end
				end
				ST_MID_RD:   state_q <= ST_MID_WAIT;
				ST_MID_WAIT: state_q <= ST_MID_CMP;
				ST_MID_CMP: begin
					if (xs < rd_s) begin
						hi_q <= mid;
						state_q <= (mid - IdxW1'(1) == lo_q) ? ST_LO_RD : ST_MID_RD;
					end else begin
						lo_q <= mid;
						state_q <= (hi_q - IdxW1'(1) == mid) ? ST_LO_RD : ST_MID_RD;
					end
				end
				ST_LO_RD: state_q <= ST_HI_RD;
				ST_HI_RD: begin
					glo_q <= rd_s;
					state_q <= ST_HI_WAIT;
				end
				ST_HI_WAIT: begin
					ghi_q <= rd_s;
					state_q <= ST_DIV_SET;
				end
				ST_DIV_SET: begin
					up_q[ax_q] <= 6'(hi_q);
					neg_q  <= numd[DenW-1] ^ den[DenW-1];
					dmag_q <= den[DenW-1] ? DenW'(-den) : den;
					quo_q  <= {1'b0, (numd[DenW-1] ? DenW'(-numd) : numd), 16'd0};
					rem_q  <= '0;
					dcnt_q <= CntW'(NumW);
					if (den == '0) begin
						fr_q[ax_q] <= '0;
						zmask_q[ax_q] <= 1'b1;
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (trial[DenW]) begin
						rem_q <= {rem_q[DenW-2:0], quo_q[NumW-1]};
						quo_q <= {quo_q[NumW-2:0], 1'b0};
					end else begin
						rem_q <= trial[DenW-1:0];
						quo_q <= {quo_q[NumW-2:0], 1'b1};
					end
					dcnt_q <= dcnt_q - CntW'(1);
					if (dcnt_q == CntW'(1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (zmask_q[ax_q] == 1'b0 && 32'(ax_q) < NUM_AXES) begin
						fr_q[ax_q] <= fsat;
					end
					if (ax_q == 2'd2) begin
						state_q <= ST_OUT;
					end else begin
						ax_q <= ax_q + 2'd1;
						state_q <= ST_AXIS;
					end
				end
				ST_OUT: begin
					if (!m_tvalid || m_tready) begin
						out_q <= {zmask_q, fr_q[2], fr_q[1], fr_q[0], up_q[2], up_q[1], up_q[0]};
						m_tvalid <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tdata = {{(gil_pkg::OutTw - gil_pkg::OutW){1'b0}}, out_q};

`ifndef ASSERT_OFF
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == ST_IDLE) else $error("ready outside idle");
	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> dcnt_q != '0) else $error("divider count underflow");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
	a_search: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MID_CMP |-> hi_q > lo_q + IdxW1'(1)) else $error("bad bracket");
`endif

endmodule

// ===== rtl/gil_ram.sv =====
module gil_ram #(
	parameter int Width = 32,
	parameter int Depth = 192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	// single write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
